// File: rtl/bilinear_texture_sampler_macros.svh
// Assertion macros used by bilinear_texture_sampler.
// Needs clk_i and rst_ni in the scope of the module that asserts.
`ifndef BILINEAR_TEXTURE_SAMPLER_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define BTS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bts_pkg.sv
// Types and constants of the bilinear texture sampler.
// No dependencies; used by bts_geom and bilinear_texture_sampler.
package bts_pkg;

  localparam int unsigned SizeW     = 13;  // texture size and texel index
  localparam int unsigned PosW      = 21;  // pixel position, 8 fraction bits
  localparam int unsigned WeightW   = 17;  // blend weight, up to 1.0 = 65536
  localparam int unsigned AccW      = 24;  // channel sum before the final shift
  localparam int unsigned MaxAddrW  = 24;  // widest store address
  localparam int unsigned ByteAddrW = 18;
  localparam int unsigned CoordW    = 24;
  localparam int unsigned ColorW    = 16;
  localparam int unsigned ChanW     = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned Texels    = 4;
  localparam int unsigned Channels  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTexWidth     = 2'd0,
    CfgTexHeight    = 2'd1,
    CfgChannelCount = 2'd2,
    CfgFilterMode   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ActWrite  = 1'b0,
    ActSample = 1'b1
  } action_e;

  typedef enum logic {
    FilterNearest  = 1'b0,
    FilterBilinear = 1'b1
  } filter_e;

  // Texel byte addresses and blend weights of one sample item.
  // Order: (x0,y0), (x1,y0), (x0,y1), (x1,y1).
  typedef struct packed {
    logic                                valid;
    logic [Texels-1:0][MaxAddrW-1:0]     base;
    logic [Texels-1:0][WeightW-1:0]      weight;
  } geom_t;

endpackage

// File: rtl/bts_geom.sv
// Coordinate pipeline: wrap, scale, neighbor selection, weights, texel addresses.
// Depends on bts_pkg; instantiated by bilinear_texture_sampler.
module bts_geom #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bts_pkg::CoordW-1:0]     coord_u_i,
  input  logic [bts_pkg::CoordW-1:0]     coord_v_i,
  input  logic [bts_pkg::SizeW-1:0]      tex_width_i,
  input  logic [bts_pkg::SizeW-1:0]      tex_height_i,
  input  logic [bts_pkg::ChanW-1:0]      channel_count_i,
  input  logic                           filter_mode_i,
  output bts_pkg::geom_t                 geom_o
);

  localparam int unsigned FracW = COORD_FRAC_BITS;
  localparam int unsigned ProdW = FracW + bts_pkg::SizeW;
  localparam int unsigned SizeW = bts_pkg::SizeW;
  localparam int unsigned PosW  = bts_pkg::PosW;
  localparam int unsigned RowW  = 2 * SizeW;
  localparam int unsigned IdxW  = RowW + 1;
  localparam int unsigned AdrPW = IdxW + bts_pkg::ChanW;
  localparam int unsigned WtW   = bts_pkg::WeightW;

  logic [SizeW-1:0] w_eff, h_eff, wm1, hm1;

  logic             v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [FracW-1:0] frac_u_q, frac_v_q;
  logic [ProdW-1:0] prod_u, prod_v;
  logic [PosW-1:0]  pu_q, pv_q;
  logic [PosW:0]    rnd_u, rnd_v;
  logic [SizeW-1:0] pi_u, pi_v, p1_u, p1_v;
  logic [SizeW-1:0] x0_d, x1_d, y0_d, y1_d;
  logic [7:0]       dx_d, dy_d;
  logic [SizeW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic [7:0]       dx_q, dy_q;
  logic [8:0]       ix, iy;
  logic [17:0]      w00, w10, w01, w11;
  logic [RowW-1:0]  row0_q, row1_q;
  logic [SizeW-1:0] x0_s4_q, x1_s4_q;
  logic [bts_pkg::Texels-1:0][WtW-1:0] wt_s4_q;
  logic [IdxW-1:0]  idx [bts_pkg::Texels];
  logic [AdrPW-1:0] adr [bts_pkg::Texels];
  logic [bts_pkg::Texels-1:0][bts_pkg::MaxAddrW-1:0] base_q;
  logic [bts_pkg::Texels-1:0][WtW-1:0] wt_q;

  // A zero size counts as one.
  assign w_eff = (tex_width_i  == '0) ? SizeW'(1) : tex_width_i;
  assign h_eff = (tex_height_i == '0) ? SizeW'(1) : tex_height_i;
  assign wm1   = w_eff - SizeW'(1);
  assign hm1   = h_eff - SizeW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage 1: wrap to the fractional part.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      frac_u_q <= coord_u_i[FracW-1:0];
      frac_v_q <= coord_v_i[FracW-1:0];
    end
  end

  // Stage 2: scale by size minus one, keep 8 fraction bits.
  assign prod_u = {{SizeW{1'b0}}, frac_u_q} * {{FracW{1'b0}}, wm1};
  assign prod_v = {{SizeW{1'b0}}, frac_v_q} * {{FracW{1'b0}}, hm1};

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      pu_q <= prod_u[ProdW-1:FracW-8];
      pv_q <= prod_v[ProdW-1:FracW-8];
    end
  end

  // Stage 3: pick texel indices and fractions.
  assign rnd_u = {1'b0, pu_q} + (PosW+1)'(128);
  assign rnd_v = {1'b0, pv_q} + (PosW+1)'(128);
  assign pi_u  = pu_q[PosW-1:8];
  assign pi_v  = pv_q[PosW-1:8];
  assign p1_u  = (pi_u >= wm1) ? wm1 : pi_u + SizeW'(1);
  assign p1_v  = (pi_v >= hm1) ? hm1 : pi_v + SizeW'(1);

  always_comb begin
    if (filter_mode_i == bts_pkg::FilterBilinear) begin
      x0_d = pi_u;
      x1_d = p1_u;
      y0_d = pi_v;
      y1_d = p1_v;
      dx_d = pu_q[7:0];
      dy_d = pv_q[7:0];
    end else begin
      // Round half up; zero fractions put the whole weight on the first texel.
      x0_d = rnd_u[PosW-1:8];
      x1_d = rnd_u[PosW-1:8];
      y0_d = rnd_v[PosW-1:8];
      y1_d = rnd_v[PosW-1:8];
      dx_d = '0;
      dy_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      x0_q <= x0_d;
      x1_q <= x1_d;
      y0_q <= y0_d;
      y1_q <= y1_d;
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // Stage 4: row offsets and weights.
  assign ix  = 9'd256 - {1'b0, dx_q};
  assign iy  = 9'd256 - {1'b0, dy_q};
  assign w00 = {9'b0, ix}        * {9'b0, iy};
  assign w10 = {10'b0, dx_q}     * {9'b0, iy};
  assign w01 = {9'b0, ix}        * {10'b0, dy_q};
  assign w11 = {10'b0, dx_q}     * {10'b0, dy_q};

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      row0_q     <= {{SizeW{1'b0}}, y0_q} * {{SizeW{1'b0}}, w_eff};
      row1_q     <= {{SizeW{1'b0}}, y1_q} * {{SizeW{1'b0}}, w_eff};
      x0_s4_q    <= x0_q;
      x1_s4_q    <= x1_q;
      wt_s4_q[0] <= w00[WtW-1:0];
      wt_s4_q[1] <= w10[WtW-1:0];
      wt_s4_q[2] <= w01[WtW-1:0];
      wt_s4_q[3] <= w11[WtW-1:0];
    end
  end

  // Stage 5: byte address of each texel, low bits only.
  assign idx[0] = {1'b0, row0_q} + {{(IdxW-SizeW){1'b0}}, x0_s4_q};
  assign idx[1] = {1'b0, row0_q} + {{(IdxW-SizeW){1'b0}}, x1_s4_q};
  assign idx[2] = {1'b0, row1_q} + {{(IdxW-SizeW){1'b0}}, x0_s4_q};
  assign idx[3] = {1'b0, row1_q} + {{(IdxW-SizeW){1'b0}}, x1_s4_q};

  for (genvar t = 0; t < bts_pkg::Texels; t++) begin : g_adr
    assign adr[t] = {{bts_pkg::ChanW{1'b0}}, idx[t]}
                  * {{IdxW{1'b0}}, channel_count_i};
  end

  always_ff @(posedge clk_i) begin
    if (v4_q) begin
      for (int t = 0; t < bts_pkg::Texels; t++) begin
        base_q[t] <= adr[t][bts_pkg::MaxAddrW-1:0];
      end
      wt_q <= wt_s4_q;
    end
  end

  assign geom_o.valid  = v5_q;
  assign geom_o.base   = base_q;
  assign geom_o.weight = wt_q;

endmodule

// File: rtl/bilinear_texture_sampler.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+------------------------------------------------
// in        | in_valid_i / in_ready_o | action_i, byte_address_i, byte_value_i,
//           |                         | coord_u_i, coord_v_i
// out       | out_valid_o/out_ready_i | red_o, green_o, blue_o
// cfg       | cfg_we_i (no wait)      | cfg_index_i, cfg_wdata_i
//
// Byte writes can follow each other every cycle while no sample is in progress.
// A sample runs a setup phase, one store read per byte and a drain state:
// 3 reads nearest, 12 bilinear; the next item can be taken in the drain state
// when the output register can load. The single-port byte store serializes
// the reads. Reset clears control and configuration; the store holds garbage
// until written. A full output register stalls the drain.
// Depends on bts_pkg, bts_geom and bilinear_texture_sampler_macros.svh.
`include "bilinear_texture_sampler_macros.svh"

module bilinear_texture_sampler #(
  parameter int unsigned STORE_BYTES     = 262144,  // power of two
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bts_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bts_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [bts_pkg::ByteAddrW-1:0]   byte_address_i,
  input  logic [7:0]                      byte_value_i,
  input  logic signed [bts_pkg::CoordW-1:0] coord_u_i,
  input  logic signed [bts_pkg::CoordW-1:0] coord_v_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bts_pkg::ColorW-1:0]      red_o,
  output logic [bts_pkg::ColorW-1:0]      green_o,
  output logic [bts_pkg::ColorW-1:0]      blue_o
);

  localparam int unsigned AddrW = $clog2(STORE_BYTES);
  localparam int unsigned AccW  = bts_pkg::AccW;
  localparam int unsigned WtW   = bts_pkg::WeightW;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StSetup = 5'b00010,
    StRead  = 5'b00100,
    StDrain = 5'b01000,
    StHold  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [bts_pkg::SizeW-1:0] tex_width_q, tex_height_q;
  logic [bts_pkg::ChanW-1:0] channel_count_q;
  logic                      filter_mode_q;

  logic in_acc, sample_acc, write_acc, out_can_load, out_load;
  bts_pkg::geom_t geom;

  logic [1:0]       tex_q, tex_d, ch_q, ch_d, last_tex;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [bts_pkg::MaxAddrW-1:0] wr_addr_ext;
  logic             mem_re;
  logic [7:0]       image_store [STORE_BYTES];
  logic [7:0]       rd_data_q;
  logic             rd_valid_q;
  logic [1:0]       rd_ch_q;
  logic [WtW-1:0]   rd_wt_q;
  logic [WtW+7:0]   prod;
  logic [bts_pkg::Channels-1:0][AccW-1:0] acc_q, acc_d;
  logic             out_valid_q;
  logic [bts_pkg::ColorW-1:0] red_q, green_q, blue_q;
  logic [WtW+1:0]   wt_sum;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q     <= bts_pkg::SizeW'(1);
      tex_height_q    <= bts_pkg::SizeW'(1);
      channel_count_q <= bts_pkg::ChanW'(3);
      filter_mode_q   <= bts_pkg::FilterNearest;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bts_pkg::CfgTexWidth:     tex_width_q     <= cfg_wdata_i;
        bts_pkg::CfgTexHeight:    tex_height_q    <= cfg_wdata_i;
        bts_pkg::CfgChannelCount: channel_count_q <= cfg_wdata_i[bts_pkg::ChanW-1:0];
        bts_pkg::CfgFilterMode:   filter_mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign out_can_load = !out_valid_q || out_ready_i;
  assign in_ready_o   = (state_q == StIdle) || ((state_q == StDrain) && out_can_load);
  assign in_acc       = in_valid_i && in_ready_o;
  assign sample_acc   = in_acc && (action_i == bts_pkg::ActSample);
  assign write_acc    = in_acc && (action_i == bts_pkg::ActWrite);

  bts_geom #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_geom (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (sample_acc),
    .coord_u_i      (coord_u_i),
    .coord_v_i      (coord_v_i),
    .tex_width_i    (tex_width_q),
    .tex_height_i   (tex_height_q),
    .channel_count_i(channel_count_q),
    .filter_mode_i  (filter_mode_q),
    .geom_o         (geom)
  );

  assign last_tex = (filter_mode_q == bts_pkg::FilterBilinear) ? 2'd3 : 2'd0;

  // Sequencer: one store read per cycle, texel by texel, channels 0..2.
  always_comb begin
    state_d  = state_q;
    tex_d    = tex_q;
    ch_d     = ch_q;
    out_load = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (sample_acc) state_d = StSetup;
      end
      StSetup: begin
        if (geom.valid) begin
          state_d = StRead;
          tex_d   = '0;
          ch_d    = '0;
        end
      end
      StRead: begin
        if (ch_q == 2'd2) begin
          ch_d = '0;
          if (tex_q == last_tex) state_d = StDrain;
          else tex_d = tex_q + 2'd1;
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
      StDrain: begin
        if (out_can_load) begin
          out_load = 1'b1;
          state_d  = sample_acc ? StSetup : StIdle;
        end else begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (out_can_load) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tex_q   <= '0;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      tex_q   <= tex_d;
      ch_q    <= ch_d;
    end
  end

  // Byte store: single port, writes only while no read is in flight.
  assign wr_addr_ext = {{(bts_pkg::MaxAddrW-bts_pkg::ByteAddrW){1'b0}}, byte_address_i};
  assign wr_addr     = wr_addr_ext[AddrW-1:0];
  assign rd_addr     = geom.base[tex_q][AddrW-1:0] + {{(AddrW-2){1'b0}}, ch_q};
  assign mem_re      = (state_q == StRead);

  always_ff @(posedge clk_i) begin
    if (write_acc) begin
      image_store[wr_addr] <= byte_value_i;
    end else if (mem_re) begin
      rd_data_q <= image_store[rd_addr];
    end
  end

  // Tag the read so the weight and channel line up with the returned byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_ch_q <= ch_q;
      rd_wt_q <= geom.weight[tex_q];
    end
  end

  assign prod = {{WtW{1'b0}}, rd_data_q} * {8'b0, rd_wt_q};

  always_comb begin
    acc_d = acc_q;
    if ((state_q == StSetup) && geom.valid) begin
      acc_d = '0;
    end else if (rd_valid_q) begin
      for (int c = 0; c < bts_pkg::Channels; c++) begin
        if (rd_ch_q == 2'(c)) acc_d[c] = acc_q[c] + prod[AccW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Output register parts the sequencer from the result channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q   <= acc_d[0][AccW-1:8];
      green_q <= acc_d[1][AccW-1:8];
      blue_q  <= acc_d[2][AccW-1:8];
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  assign wt_sum = {2'b0, geom.weight[0]} + {2'b0, geom.weight[1]}
                + {2'b0, geom.weight[2]} + {2'b0, geom.weight[3]};

  `BTS_ASSERT_IMP(a_geom_in_setup, geom.valid, state_q == StSetup, "geometry outside setup")
  `BTS_ASSERT_IMP(a_weights_unit, geom.valid, wt_sum == (WtW+2)'(65536),
                  "weights do not sum to one")
  `BTS_ASSERT_IMP(a_drain_has_data, state_q == StDrain, rd_valid_q, "drain without read data")
  `BTS_ASSERT(a_no_stray_read, !((state_q == StIdle) && rd_valid_q), "read data while idle")
  `BTS_ASSERT_IMP(a_result_source, $rose(out_valid_q),
                  $past(state_q == StDrain || state_q == StHold),
                  "result without a finished sample")

endmodule
